[hdl/bit_field_unpacker_top_macros.svh]
// assertion macros for the bit field unpacker top level
// expects clk and rst_n in the scope where a macro is used
`ifndef BIT_FIELD_UNPACKER_TOP_MACROS_SVH
`define BIT_FIELD_UNPACKER_TOP_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define BFU_CHECK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define BFU_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/bfu_pkg.sv]
// shared constants, tables and types for the bit field unpacker
// no dependencies
`default_nettype none

package bfu_pkg;

    localparam int WORD_W         = 16;
    localparam int BYTE_W         = 8;
    localparam int FIELD_NUM_W    = 8;
    localparam int FIELD_CNT_W    = 9;
    localparam int ENTRY_IDX_W    = 8;
    localparam int ENTRY_WID_W    = 5;
    localparam int REM_W          = 5;
    localparam int CARRY_W        = 15;
    localparam int CARRY_CNT_W    = 4;
    localparam int TBL_DATA_W     = 4;
    localparam int TBL_ADDR_MAX   = 12;
    localparam int MAX_FIELDS_DEF = 256;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_COUNT = 1'd1;

    // request codes
    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    // right-aligned masks of 0 to 16 ones
    localparam logic [WORD_W-1:0] LOW_MASK [0:WORD_W] = '{
        16'h0000, 16'h0001, 16'h0003, 16'h0007, 16'h000F, 16'h001F, 16'h003F,
        16'h007F, 16'h00FF, 16'h01FF, 16'h03FF, 16'h07FF, 16'h0FFF, 16'h1FFF,
        16'h3FFF, 16'h7FFF, 16'hFFFF
    };

    // width table port requests
    typedef struct packed {
        logic                    wr_en;
        logic [TBL_ADDR_MAX-1:0] wr_addr;
        logic [TBL_DATA_W-1:0]   wr_data;
        logic [TBL_ADDR_MAX-1:0] rd_addr;
    } tbl_req_t;

    // extractor status seen by the top level
    typedef struct packed {
        logic busy;
        logic nf_zero;
    } bfu_stat_t;

endpackage

`default_nettype wire

[hdl/bfu_width_mem.sv]
// width table: one write port, one registered read port
// depends on bfu_pkg
`default_nettype none

module bfu_width_mem #(
    parameter int MAX_FIELDS = bfu_pkg::MAX_FIELDS_DEF
) (
    input  wire logic                             clk,
    input  wire bfu_pkg::tbl_req_t                req,
    output logic [bfu_pkg::TBL_DATA_W-1:0]        rdata
);
    import bfu_pkg::*;

    localparam int AW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;

    logic [TBL_DATA_W-1:0] mem [MAX_FIELDS];
    logic [TBL_DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr[AW-1:0]] <= req.wr_data;
        end
        rdata_reg <= mem[req.rd_addr[AW-1:0]];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hdl/bfu_extract.sv]
// field extraction sequencer with table loads and the output register
// depends on bfu_pkg; drives the width table ports
`default_nettype none

module bfu_extract #(
    parameter int MAX_FIELDS = bfu_pkg::MAX_FIELDS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              req_type,
    input  wire logic [bfu_pkg::BYTE_W-1:0]        first_byte,
    input  wire logic [bfu_pkg::BYTE_W-1:0]        second_byte,
    input  wire logic [bfu_pkg::ENTRY_IDX_W-1:0]   entry_index,
    input  wire logic [bfu_pkg::ENTRY_WID_W-1:0]   entry_width,
    input  wire logic                              big_endian,
    input  wire logic [bfu_pkg::FIELD_CNT_W-1:0]   field_count,
    input  wire logic [bfu_pkg::TBL_DATA_W-1:0]    tbl_rdata,
    output bfu_pkg::tbl_req_t                      tbl_req,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [bfu_pkg::FIELD_NUM_W-1:0]        field_number,
    output logic [bfu_pkg::WORD_W-1:0]             field_value,
    output logic                                   last_field,
    output bfu_pkg::bfu_stat_t                     stat
);
    import bfu_pkg::*;

    localparam int NF_W  = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
    localparam int CMP_W = (NF_W + 1 > FIELD_CNT_W) ? NF_W + 1 : FIELD_CNT_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                   state_reg, state_next;
    logic [WORD_W-1:0]      word_reg, word_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [NF_W-1:0]        nf_reg, nf_next;
    logic [CARRY_W-1:0]     carry_bits_reg, carry_bits_next;
    logic [CARRY_CNT_W-1:0] carry_cnt_reg, carry_cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [FIELD_NUM_W-1:0] field_number_reg, field_number_next;
    logic [WORD_W-1:0]      field_value_reg, field_value_next;
    logic                   last_field_reg, last_field_next;

    logic                   in_acc;
    logic                   out_free;
    logic [REM_W-1:0]       fw;
    logic [REM_W-1:0]       cc_ext;
    logic [REM_W-1:0]       need;
    logic [REM_W-1:0]       shift_amt;
    logic [REM_W-1:0]       cc_sum;
    logic [31:0]            carry_ext;
    logic [31:0]            word_ext;
    logic [31:0]            fv_full;
    logic [31:0]            cb_full;
    logic [CMP_W-1:0]       fc_ext;
    logic [CMP_W-1:0]       count_eff;
    logic                   is_last;
    logic [ENTRY_WID_W-1:0] wid_clamp;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // bits still missing from the current field
    assign fw        = {1'b0, tbl_rdata} + REM_W'(1);
    assign cc_ext    = {1'b0, carry_cnt_reg};
    assign need      = (fw > cc_ext) ? (fw - cc_ext) : REM_W'(1);
    assign shift_amt = rem_reg - need;
    assign cc_sum    = cc_ext + rem_reg;

    assign carry_ext = 32'(carry_bits_reg);
    assign word_ext  = 32'(word_reg);
    assign fv_full   = (carry_ext << need)
                     | ((word_ext >> shift_amt) & 32'(LOW_MASK[need]));
    assign cb_full   = (carry_ext << rem_reg) | (word_ext & 32'(LOW_MASK[rem_reg]));

    // section length clamped to 1 .. MAX_FIELDS
    assign fc_ext = CMP_W'(field_count);
    always_comb
    begin
        if (field_count == '0)
        begin
            count_eff = CMP_W'(1);
        end
        else if (fc_ext > CMP_W'(MAX_FIELDS))
        begin
            count_eff = CMP_W'(MAX_FIELDS);
        end
        else
        begin
            count_eff = fc_ext;
        end
    end

    assign is_last = (CMP_W'(nf_reg) + CMP_W'(1)) >= count_eff;

    always_comb
    begin
        if (entry_width == '0)
        begin
            wid_clamp = ENTRY_WID_W'(1);
        end
        else if (entry_width > ENTRY_WID_W'(WORD_W))
        begin
            wid_clamp = ENTRY_WID_W'(WORD_W);
        end
        else
        begin
            wid_clamp = entry_width;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        word_next         = word_reg;
        rem_next          = rem_reg;
        nf_next           = nf_reg;
        carry_bits_next   = carry_bits_reg;
        carry_cnt_next    = carry_cnt_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        field_number_next = field_number_reg;
        field_value_next  = field_value_reg;
        last_field_next   = last_field_reg;
        tbl_req.wr_en     = 1'b0;
        tbl_req.wr_addr   = TBL_ADDR_MAX'(entry_index);
        tbl_req.wr_data   = TBL_DATA_W'(wid_clamp - ENTRY_WID_W'(1));

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (req_type == REQ_LOAD)
                    begin
                        tbl_req.wr_en = (32'(entry_index) < 32'(MAX_FIELDS));
                    end
                    else
                    begin
                        word_next  = big_endian ? {first_byte, second_byte}
                                                : {second_byte, first_byte};
                        rem_next   = REM_W'(WORD_W);
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (need > rem_reg)
                begin
                    // field straddles into the next word
                    carry_bits_next = cb_full[CARRY_W-1:0];
                    carry_cnt_next  = cc_sum[CARRY_CNT_W-1:0];
                    state_next      = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    field_number_next = FIELD_NUM_W'(nf_reg);
                    field_value_next  = fv_full[WORD_W-1:0];
                    last_field_next   = is_last;
                    carry_bits_next   = '0;
                    carry_cnt_next    = '0;
                    rem_next          = rem_reg - need;
                    if (is_last)
                    begin
                        // rest of the word is dropped
                        nf_next    = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        nf_next = nf_reg + NF_W'(1);
                        if (rem_reg == need)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // table read follows the field index so the width is ready next cycle
        tbl_req.rd_addr = TBL_ADDR_MAX'(nf_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            nf_reg         <= '0;
            carry_bits_reg <= '0;
            carry_cnt_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            nf_reg         <= nf_next;
            carry_bits_reg <= carry_bits_next;
            carry_cnt_reg  <= carry_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg         <= word_next;
        rem_reg          <= rem_next;
        field_number_reg <= field_number_next;
        field_value_reg  <= field_value_next;
        last_field_reg   <= last_field_next;
    end

    assign out_valid    = out_valid_reg;
    assign field_number = field_number_reg;
    assign field_value  = field_value_reg;
    assign last_field   = last_field_reg;

    assign stat.busy    = (state_reg == ST_RUN);
    assign stat.nf_zero = (nf_reg == '0);

endmodule

`default_nettype wire

[hdl/bit_field_unpacker_top.sv]
// bit field unpacker top level: config registers, width table, extractor
// a load transaction writes the width table on acceptance; a data word is accepted in idle,
// then the run state emits each field it completes and keeps a straddling field as carry;
// a new word waits for run to end; run loads the output register; a held output stalls
// reset clears position, carry and output valid, big_endian to 1, field_count to 1;
// the width table is not cleared. depends on bfu_pkg, bfu_width_mem, bfu_extract
`default_nettype none
`include "bit_field_unpacker_top_macros.svh"

module bit_field_unpacker_top #(
    parameter int MAX_FIELDS = bfu_pkg::MAX_FIELDS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bfu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bfu_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              req_type,
    input  wire logic [bfu_pkg::BYTE_W-1:0]        first_byte,
    input  wire logic [bfu_pkg::BYTE_W-1:0]        second_byte,
    input  wire logic [bfu_pkg::ENTRY_IDX_W-1:0]   entry_index,
    input  wire logic [bfu_pkg::ENTRY_WID_W-1:0]   entry_width,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [bfu_pkg::FIELD_NUM_W-1:0]        field_number,
    output logic [bfu_pkg::WORD_W-1:0]             field_value,
    output logic                                   last_field
);
    import bfu_pkg::*;

    logic                   big_endian_reg, big_endian_next;
    logic [FIELD_CNT_W-1:0] field_count_reg, field_count_next;
    tbl_req_t               tbl_req;
    logic [TBL_DATA_W-1:0]  tbl_rdata;
    bfu_stat_t              stat;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        big_endian_next  = big_endian_reg;
        field_count_next = field_count_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BIG_ENDIAN:  big_endian_next  = cfg_data[0];
                CFG_FIELD_COUNT: field_count_next = FIELD_CNT_W'(cfg_data);
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            big_endian_reg  <= 1'b1;
            field_count_reg <= FIELD_CNT_W'(1);
        end
        else
        begin
            big_endian_reg  <= big_endian_next;
            field_count_reg <= field_count_next;
        end
    end

    bfu_width_mem #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_width_mem (
        .clk   (clk),
        .req   (tbl_req),
        .rdata (tbl_rdata)
    );

    bfu_extract #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_extract (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .first_byte   (first_byte),
        .second_byte  (second_byte),
        .entry_index  (entry_index),
        .entry_width  (entry_width),
        .big_endian   (big_endian_reg),
        .field_count  (field_count_reg),
        .tbl_rdata    (tbl_rdata),
        .tbl_req      (tbl_req),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .field_number (field_number),
        .field_value  (field_value),
        .last_field   (last_field),
        .stat         (stat)
    );

    // a table load never starts a result
    `BFU_CHECK_NEXT(a_load_no_result, in_valid && in_ready && req_type == REQ_LOAD && !out_valid, !out_valid, "load transaction produced a result")

    // an accepted data word always starts extraction
    `BFU_CHECK_NEXT(a_data_starts_run, in_valid && in_ready && req_type == REQ_DATA, stat.busy, "data word did not start extraction")

    // after the last field of a section the position is back at field zero
    `BFU_CHECK_SAME(a_last_wraps, out_valid && last_field, stat.nf_zero, "position not reset after last field")

endmodule

`default_nettype wire
